@@ rtl/core/ffc_pkg.sv @@
// Constants and conversion functions for the float format converter.
package ffc_pkg;

  localparam logic [7:0]  ExpMax   = 8'hFF;
  localparam logic [22:0] QuietBit = 23'h400000;

  localparam logic OpToIeee   = 1'b0;
  localparam logic OpFromIeee = 1'b1;

  // Halve an IEEE single, round to nearest even.
  function automatic logic [31:0] halve_ieee(input logic [31:0] x);
    logic        s;
    logic [7:0]  e;
    logic [22:0] m;
    logic [23:0] sig;
    logic [23:0] q;
    s = x[31];
    e = x[30:23];
    m = x[22:0];
    sig = (e != 8'd0) ? {1'b1, m} : {1'b0, m};
    q = {1'b0, sig[23:1]};
    if (sig[0] && q[0]) q = q + 24'd1;
    if (e == ExpMax) begin
      halve_ieee = {s, ExpMax, (m != 23'd0) ? (m | QuietBit) : 23'd0};
    end else if (e >= 8'd2) begin
      halve_ieee = {s, e - 8'd1, m};
    end else begin
      halve_ieee = {s, 7'd0, q};
    end
  endfunction

  // Double an IEEE single.
  function automatic logic [31:0] double_ieee(input logic [31:0] x);
    logic        s;
    logic [7:0]  e;
    logic [22:0] m;
    s = x[31];
    e = x[30:23];
    m = x[22:0];
    if (e == ExpMax) begin
      double_ieee = {s, ExpMax, (m != 23'd0) ? (m | QuietBit) : 23'd0};
    end else if (e == ExpMax - 8'd1) begin
      double_ieee = {s, ExpMax, 23'd0};
    end else if (e != 8'd0) begin
      double_ieee = {s, e + 8'd1, m};
    end else begin
      double_ieee = {s, 7'd0, m, 1'b0};
    end
  endfunction

endpackage

@@ rtl/core/float_format_converter.sv @@
// Converter between the bias-128 internal float layout and IEEE 754 single.
// Path: the input register holds the accepted word, then the result register drives result valid.
// Throughput: one item per cycle while the result side is ready; conversion is a single combinational pass.
// While a result waits, input is taken only if the input register is empty.
// Reset (rst_ni low, async) clears both valid flags; data registers are not reset.
module float_format_converter
  import ffc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // word_in[31:0]
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // word_out[31:0]
);

  logic        in_vld_q;
  logic        in_op_q;
  logic [31:0] in_word_q;
  logic        out_vld_q;
  logic [31:0] out_word_q;
  logic [31:0] res_d;
  logic [31:0] ieee;
  logic [31:0] dbl;
  logic        out_free;
  logic        in_free;

  assign out_free = !out_vld_q || m_axis_tready;
  assign in_free  = !in_vld_q || out_free;
  assign s_axis_tready = in_free;

  always_comb begin
    ieee = halve_ieee({in_word_q[23], in_word_q[31:24], in_word_q[22:0]});
    dbl  = double_ieee(in_word_q);
    if (in_op_q == OpToIeee) begin
      res_d = ieee;
    end else begin
      res_d = {dbl[30:23], dbl[31], dbl[22:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_free) in_vld_q <= s_axis_tvalid;
      if (out_free) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_word_q <= s_axis_tdata;
    end
    if (out_free && in_vld_q) out_word_q <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_word_q;

endmodule

@@ tb/float_format_converter_tb.sv @@
// Testbench for float_format_converter: directed and random words, checked against a predictor.
module float_format_converter_tb;
  import ffc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  logic [31:0] expected_words[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;
  localparam int IdleLimit = 2000;

  float_format_converter uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Halve an IEEE single with round to nearest even.
  function automatic logic [31:0] halve_single(input logic [31:0] x);
    logic [7:0]  e;
    logic [22:0] f;
    logic [23:0] sig;
    logic [23:0] q;
    e = x[30:23];
    f = x[22:0];
    if (e == 8'hFF) return {x[31], 8'hFF, (f != 23'd0) ? (f | 23'h400000) : 23'd0};
    if (e >= 8'd2) return {x[31], e - 8'd1, f};
    sig = {(e != 8'd0), f};
    q = sig >> 1;
    if (sig[0] && q[0]) q = q + 24'd1;
    return {x[31], 7'd0, q};
  endfunction

  function automatic logic [31:0] double_single(input logic [31:0] x);
    logic [7:0]  e;
    logic [22:0] f;
    e = x[30:23];
    f = x[22:0];
    if (e == 8'hFF) return {x[31], 8'hFF, (f != 23'd0) ? (f | 23'h400000) : 23'd0};
    if (e == 8'hFE) return {x[31], 8'hFF, 23'd0};
    if (e != 8'd0) return {x[31], e + 8'd1, f};
    return {x[31], 7'd0, f, 1'b0};
  endfunction

  function automatic logic [31:0] convert_word(input logic op, input logic [31:0] w);
    logic [31:0] d;
    if (op == OpToIeee) return halve_single({w[23], w[31:24], w[22:0]});
    d = double_single(w);
    return {d[30:23], d[31], d[22:0]};
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 30);
  endfunction

  // Valid stays high between back-to-back items; it drops only for an idle gap.
  task automatic send_word(input logic op, input logic [31:0] w);
    if (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (idle_now());
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_words.push_back(convert_word(op, w));
  endtask

  // Result side: random stalls, compare with oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          logic [31:0] exp_w;
          exp_w = expected_words.pop_front();
          if (exp_w !== m_axis_tdata) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word_out mismatch: expected %h actual %h", exp_w, m_axis_tdata);
          end
        end
      end
      m_axis_tready <= !idle_now();
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("float_format_converter_tb failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word(input logic op);
    logic [31:0] w;
    logic [7:0]  e;
    w = $urandom();
    case ($urandom_range(5))
      0: e = 8'h00;
      1: e = 8'h01;
      2: e = 8'hFF;
      3: e = 8'hFE;
      default: e = 8'($urandom_range(255));
    endcase
    if (op == OpToIeee) w[31:24] = e;
    else w[30:23] = e;
    return w;
  endfunction

  task automatic test_internal_to_ieee();
    send_word(OpToIeee, 32'h0000_0000);
    send_word(OpToIeee, 32'h0080_0000);             // negative zero
    send_word(OpToIeee, 32'hFF00_0000);             // infinity
    send_word(OpToIeee, 32'hFF80_0000);
    send_word(OpToIeee, 32'hFF00_0001);             // NaN, quiet bit forced
    send_word(OpToIeee, 32'hFFFF_FFFF);
    send_word(OpToIeee, 32'h0100_0000);             // smallest normal halves below range
    send_word(OpToIeee, 32'h017F_FFFF);             // rounds up into normal
    send_word(OpToIeee, 32'h0000_0003);             // tie, round to even
    send_word(OpToIeee, 32'h0000_0001);
    send_word(OpToIeee, 32'h0200_0000);
    send_word(OpToIeee, 32'hFEFF_FFFF);
  endtask

  task automatic test_ieee_to_internal();
    send_word(OpFromIeee, 32'h0000_0000);
    send_word(OpFromIeee, 32'h8000_0000);
    send_word(OpFromIeee, 32'h7F80_0000);
    send_word(OpFromIeee, 32'hFF80_0000);
    send_word(OpFromIeee, 32'h7F80_0001);
    send_word(OpFromIeee, 32'h7F7F_FFFF);           // doubling overflow
    send_word(OpFromIeee, 32'h0040_0000);           // subnormal normalizes
    send_word(OpFromIeee, 32'h003F_FFFF);
    send_word(OpFromIeee, 32'hFFFF_FFFF);
    send_word(OpFromIeee, 32'h0080_0000);
  endtask

  task automatic test_random_words();
    logic op;
    for (int i = 0; i < 1600; i++) begin
      no_idle = (i >= 600 && i < 900);
      op = 1'($urandom_range(1));
      send_word(op, rand_word(op));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_internal_to_ieee();
    test_ieee_to_internal();
    test_random_words();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("float_format_converter_tb passed");
    else $display("float_format_converter_tb failed");
    $finish;
  end
endmodule

@@ float_format_converter.f @@
rtl/core/ffc_pkg.sv
rtl/core/float_format_converter.sv
tb/float_format_converter_tb.sv
